### design/pps_pkg.sv
// shared types and constants for the preemptive priority scheduler
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

   // request and response payloads
   typedef struct packed {
      logic        command;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  prio;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        ran;
      logic [3:0]  slot;
      logic        switched;
      logic        finished;
      logic [31:0] turnaround;
      logic [31:0] waiting;
      logic [31:0] time_now;
      logic        all_done;
   } rsp_type;

   // one task table entry
   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic [7:0]  prio;
   } entry_type;

   // control from the sequencer to the selection unit
   typedef struct packed {
      logic clear;
      logic take;
   } sel_ctrl_type;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

### design/preemptive_priority_scheduler.sv
// top level of the preemptive priority scheduler: sequencer, counters, result register
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake              payload
// req      in         req_valid / req_stall  req_data  (pps_pkg::req_type)
// rsp      out        rsp_valid / rsp_stall  rsp_data  (pps_pkg::rsp_type)
//
// a load request writes the table on acceptance, then moves to the result state
// a tick request scans the task table one entry per cycle through the memory's
//   single read port (no scan with an empty table), then passes through the
//   update state and the result state
// one request is in flight at a time; req_stall is high while it is worked on
// synchronous reset clears counters, time and control; the table needs no clearing pass
// a stalled response holds in the output register; the next request is still taken

module preemptive_priority_scheduler
   import pps_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int SLOT_W = $clog2(MAX_TASKS);
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_RESULT
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   task_count_ff, task_count_in;
   logic [CNT_W-1:0]   done_count_ff, done_count_in;
   logic [31:0]        clock_time_ff, clock_time_in;
   logic [31:0]        clock_next_ff, clock_next_in;
   logic [SLOT_W-1:0]  last_slot_ff, last_slot_in;
   logic               last_valid_ff, last_valid_in;
   logic [CNT_W-1:0]   issue_idx_ff, issue_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   logic [SLOT_W-1:0]  rd_slot_ff, rd_slot_in;
   rsp_type            res_ff, res_in;
   logic [15:0]        res_burst_ff, res_burst_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // memory and selection unit
   logic               mem_wr_en;
   logic [SLOT_W-1:0]  mem_wr_addr;
   entry_type          mem_wr_data;
   logic               mem_rd_en;
   logic [SLOT_W-1:0]  mem_rd_addr;
   entry_type          mem_rd_data;
   sel_ctrl_type       sel_ctrl;
   logic               sel_found;
   logic [SLOT_W-1:0]  sel_slot;
   entry_type          sel_best;

   // misc
   logic               req_accept;
   logic               is_load;
   logic               load_reject;
   logic               rsp_free;
   logic               scan_done;
   logic [15:0]        new_remaining;
   logic               task_fin;
   logic [SLOT_W+3:0]  best_ext;
   logic [SLOT_W+3:0]  load_ext;
   logic [32:0]        wait_diff;
   logic [31:0]        wait_val;

   assign req_accept  = req_valid && (state_ff == S_IDLE);
   assign is_load     = (req_data.command == CMD_LOAD);
   assign load_reject = (req_data.burst == 16'd0) || (task_count_ff == CNT_W'(MAX_TASKS));
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign scan_done   = (issue_idx_ff == task_count_ff);

   // 4-bit slot field from slot indexes of any width
   assign best_ext = {4'b0000, sel_slot};
   assign load_ext = {4'b0000, task_count_ff[SLOT_W-1:0]};

   assign new_remaining = sel_best.remaining - 16'd1;
   assign task_fin      = (new_remaining == 16'd0);

   // waiting = turnaround - burst, floored at zero when time saturated
   assign wait_diff = {1'b0, res_ff.turnaround} - {17'd0, res_burst_ff};
   assign wait_val  = (res_ff.finished && !wait_diff[32]) ? wait_diff[31:0] : 32'd0;

   // ---------------------------------------------------------------------------
   // table memory: loads write on acceptance, the tick write-back lands in the
   // update cycle; no read is issued in either, so accesses never overlap
   // ---------------------------------------------------------------------------
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = task_count_ff[SLOT_W-1:0];
      mem_wr_data = '{arrival:   req_data.arrival,
                      burst:     req_data.burst,
                      remaining: req_data.burst,
                      prio:      req_data.prio};
      if (req_accept && is_load && !load_reject) begin
         mem_wr_en = 1'b1;
      end else if ((state_ff == S_UPDATE) && sel_found) begin
         mem_wr_en             = 1'b1;
         mem_wr_addr           = sel_slot;
         mem_wr_data           = sel_best;
         mem_wr_data.remaining = new_remaining;
      end
   end

   // scan reads: slot 0 on acceptance of a tick, then one slot per cycle
   assign mem_rd_en   = (req_accept && !is_load) || ((state_ff == S_SCAN) && !scan_done);
   assign mem_rd_addr = (state_ff == S_IDLE) ? '0 : issue_idx_ff[SLOT_W-1:0];

   pps_task_mem #(
      .DEPTH (MAX_TASKS),
      .AW    (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // read data is registered in the memory, arrives in the cycle after its address and is tagged by rd_slot_ff
   assign sel_ctrl.clear = req_accept && !is_load;
   assign sel_ctrl.take  = rd_vld_ff;

   pps_select #(
      .SW (SLOT_W)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (sel_ctrl),
      .cand_slot (rd_slot_ff),
      .cand      (mem_rd_data),
      .now       (clock_time_ff),
      .found     (sel_found),
      .best_slot (sel_slot),
      .best      (sel_best)
   );

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      task_count_in = task_count_ff;
      done_count_in = done_count_ff;
      clock_time_in = clock_time_ff;
      clock_next_in = clock_next_ff;
      last_slot_in  = last_slot_ff;
      last_valid_in = last_valid_ff;
      issue_idx_in  = issue_idx_ff;
      rd_vld_in     = 1'b0;
      rd_slot_in    = rd_slot_ff;
      res_in        = res_ff;
      res_burst_in  = res_burst_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_in       = '0;
               res_burst_in = 16'd0;
               if (is_load) begin
                  // load: append at the next free slot unless rejected
                  if (load_reject) begin
                     res_in.status = STATUS_REJECT;
                  end else begin
                     res_in.status = STATUS_OK;
                     res_in.slot   = load_ext[3:0];
                     task_count_in = task_count_ff + CNT_W'(1);
                  end
                  state_in = S_RESULT;
               end else if (task_count_ff == '0) begin
                  // empty table: idle tick
                  state_in = S_UPDATE;
               end else begin
                  issue_idx_in = CNT_W'(1);
                  rd_vld_in    = 1'b1;
                  rd_slot_in   = '0;
                  state_in     = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (scan_done) begin
               // last entry is compared this cycle
               state_in = S_UPDATE;
            end else begin
               issue_idx_in = issue_idx_ff + CNT_W'(1);
               rd_vld_in    = 1'b1;
               rd_slot_in   = issue_idx_ff[SLOT_W-1:0];
            end
         end

         S_UPDATE: begin
            // time advances, saturating
            clock_time_in = clock_next_ff;
            clock_next_in = (clock_next_ff == TIME_MAX) ? clock_next_ff
                                                         : clock_next_ff + 32'd1;
            if (sel_found) begin
               res_in.ran      = 1'b1;
               res_in.slot     = best_ext[3:0];
               res_in.switched = !last_valid_ff || (last_slot_ff != sel_slot);
               res_in.finished = task_fin;
               last_slot_in    = sel_slot;
               last_valid_in   = 1'b1;
               res_burst_in    = sel_best.burst;
               if (task_fin) begin
                  res_in.turnaround = clock_next_ff - {16'd0, sel_best.arrival};
                  done_count_in     = done_count_ff + CNT_W'(1);
               end
            end
            state_in = S_RESULT;
         end

         S_RESULT: begin
            if (rsp_free) begin
               rsp_data_in          = res_ff;
               rsp_data_in.waiting  = wait_val;
               rsp_data_in.time_now = clock_time_ff;
               rsp_data_in.all_done = (done_count_ff == task_count_ff);
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         task_count_ff <= '0;
         done_count_ff <= '0;
         clock_time_ff <= 32'd0;
         clock_next_ff <= 32'd1;
         last_slot_ff  <= '0;
         last_valid_ff <= 1'b0;
         issue_idx_ff  <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         task_count_ff <= task_count_in;
         done_count_ff <= done_count_in;
         clock_time_ff <= clock_time_in;
         clock_next_ff <= clock_next_in;
         last_slot_ff  <= last_slot_in;
         last_valid_ff <= last_valid_in;
         issue_idx_ff  <= issue_idx_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rd_slot_ff   <= rd_slot_in;
      res_ff       <= res_in;
      res_burst_ff <= res_burst_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("response raised outside the result cycle");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !mem_wr_en)
      else $error("table write during scan");

   a_done_le_tasks: assert property (@(posedge clock) disable iff (reset)
      done_count_ff <= task_count_ff)
      else $error("more finished tasks than loaded");

   a_finish_needs_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.finished || rsp_data_ff.ran))
      else $error("finished reported without a run");

   a_run_marks_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_UPDATE) && sel_found) |=> last_valid_ff)
      else $error("last task not recorded after a run");

endmodule

`default_nettype wire

### design/pps_task_mem.sv
// task table memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module pps_task_mem
   import pps_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/pps_select.sv
// running best-candidate register for the task scan
`timescale 1ns / 1ps
`default_nettype none

module pps_select
   import pps_pkg::*;
#(
   parameter int SW = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire sel_ctrl_type  ctrl,
   input  wire logic [SW-1:0] cand_slot,
   input  wire entry_type     cand,
   input  wire logic [31:0]   now,
   output logic               found,
   output logic [SW-1:0]      best_slot,
   output entry_type          best
);

   logic          found_ff;
   logic [SW-1:0] best_slot_ff;
   entry_type     best_ff;
   logic          eligible;
   logic          better;
   logic          load_best;

   // ready: not finished and already arrived
   assign eligible = (cand.remaining != 16'd0) && ({16'd0, cand.arrival} <= now);
   // scan runs in slot order, so equal priority and arrival keeps the lower slot
   assign better = !found_ff || (cand.prio < best_ff.prio) ||
                   ((cand.prio == best_ff.prio) && (cand.arrival < best_ff.arrival));
   assign load_best = ctrl.take && eligible && better;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctrl.clear) begin
         found_ff <= 1'b0;
      end else if (load_best) begin
         found_ff <= 1'b1;
      end
      if (load_best) begin
         best_ff      <= cand;
         best_slot_ff <= cand_slot;
      end
   end

   assign found     = found_ff;
   assign best_slot = best_slot_ff;
   assign best      = best_ff;

endmodule

`default_nettype wire

### tb/schedule_checker.sv
// checker for the priority scheduler: predicts each response and compares it on arrival
`timescale 1ns / 1ps

module schedule_checker
   import pps_pkg::*;
#(
   parameter int TABLE_SLOTS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           mismatches,
   output int           outstanding,
   output int           loads_taken,
   output int           loads_refused,
   output int           busy_ticks,
   output int           idle_ticks,
   output int           switches,
   output int           completions
);

   // shadow task table
   logic [15:0] task_arrival [TABLE_SLOTS];
   logic [15:0] task_burst   [TABLE_SLOTS];
   logic [15:0] task_left    [TABLE_SLOTS];
   logic [7:0]  task_prio    [TABLE_SLOTS];
   logic        task_retired [TABLE_SLOTS];
   int          loaded;
   int          retired;
   logic [31:0] now;
   int          last_ran;
   logic        last_ran_valid;

   rsp_type pending_outcomes [$];
   int      responses_seen;

   function automatic string outcome_text(input rsp_type o);
      return $sformatf("st=%0d ran=%0d slot=%0d sw=%0d fin=%0d ta=%0d wt=%0d t=%0d done=%0d",
                       o.status, o.ran, o.slot, o.switched, o.finished,
                       o.turnaround, o.waiting, o.time_now, o.all_done);
   endfunction

   function automatic rsp_type schedule_item(input req_type r);
      rsp_type     o;
      logic        found;
      int          best;
      logic [31:0] ta;
      logic [31:0] b;
      o = '0;
      if (r.command == CMD_LOAD) begin
         if (r.burst == 16'd0 || loaded >= TABLE_SLOTS) begin
            o.status = STATUS_REJECT;
         end else begin
            task_arrival[loaded] = r.arrival;
            task_burst[loaded]   = r.burst;
            task_left[loaded]    = r.burst;
            task_prio[loaded]    = r.prio;
            task_retired[loaded] = 1'b0;
            o.slot = 4'(loaded);
            loaded++;
         end
      end else begin
         found = 1'b0;
         best  = 0;
         // lowest priority number, then earliest arrival, then lowest slot
         for (int i = 0; i < loaded; i++) begin
            if (!task_retired[i] && {16'd0, task_arrival[i]} <= now) begin
               if (!found || task_prio[i] < task_prio[best] ||
                   (task_prio[i] == task_prio[best] &&
                    task_arrival[i] < task_arrival[best])) begin
                  best  = i;
                  found = 1'b1;
               end
            end
         end
         if (now != TIME_MAX)
            now++;
         if (found) begin
            o.ran      = 1'b1;
            o.slot     = 4'(best);
            o.switched = !last_ran_valid || last_ran != best;
            last_ran       = best;
            last_ran_valid = 1'b1;
            task_left[best] = task_left[best] - 16'd1;
            if (task_left[best] == 16'd0) begin
               task_retired[best] = 1'b1;
               retired++;
               ta = now - {16'd0, task_arrival[best]};
               b  = {16'd0, task_burst[best]};
               o.finished   = 1'b1;
               o.turnaround = ta;
               o.waiting    = (ta >= b) ? ta - b : 32'd0;
            end
         end
      end
      o.time_now = now;
      o.all_done = (retired == loaded);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type exp;
      rsp_type got;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            task_arrival[i] = '0;
            task_burst[i]   = '0;
            task_left[i]    = '0;
            task_prio[i]    = '0;
            task_retired[i] = 1'b0;
         end
         loaded = 0;
         retired = 0;
         now = '0;
         last_ran = 0;
         last_ran_valid = 1'b0;
         pending_outcomes.delete();
         responses_seen = 0;
         mismatches = 0;
         loads_taken = 0;
         loads_refused = 0;
         busy_ticks = 0;
         idle_ticks = 0;
         switches = 0;
         completions = 0;
         outstanding <= 0;
      end else begin
         // responses first so a spurious one is never matched to a new request
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (pending_outcomes.size() == 0) begin
               if (mismatches < 10)
                  $display("response %0d with no request outstanding: %s",
                           responses_seen, outcome_text(got));
               mismatches++;
            end else begin
               exp = pending_outcomes.pop_front();
               if (got.status !== exp.status || got.ran !== exp.ran ||
                   got.slot !== exp.slot || got.switched !== exp.switched ||
                   got.finished !== exp.finished || got.turnaround !== exp.turnaround ||
                   got.waiting !== exp.waiting || got.time_now !== exp.time_now ||
                   got.all_done !== exp.all_done) begin
                  if (mismatches < 10) begin
                     $display("response %0d mismatch, expected %s", responses_seen,
                              outcome_text(exp));
                     $display("response %0d mismatch, actual   %s", responses_seen,
                              outcome_text(got));
                  end
                  mismatches++;
               end
            end
            responses_seen++;
         end
         if (req_valid && !req_stall) begin
            exp = schedule_item(req_data);
            pending_outcomes.push_back(exp);
            if (req_data.command == CMD_LOAD) begin
               if (exp.status == STATUS_REJECT)
                  loads_refused++;
               else
                  loads_taken++;
            end else if (exp.ran) begin
               busy_ticks++;
            end else begin
               idle_ticks++;
            end
            if (exp.switched)
               switches++;
            if (exp.finished)
               completions++;
         end
         outstanding <= pending_outcomes.size();
      end
   end

endmodule

### tb/tb.sv
// top of the scheduler testbench: clock, reset, request stimulus, response stalls, verdict
`timescale 1ns / 1ps

module tb;
   import pps_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_ITEMS   = 600;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int TABLE_SLOTS    = 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int loads_taken;
   int loads_refused;
   int busy_ticks;
   int idle_ticks;
   int switches;
   int completions;

   // stimulus-side bookkeeping for the requests, the response stalls and the watchdog
   int slots_used     = 0;
   int ticks_sent     = 0;
   int send_idle_pct  = 25;
   int recv_stall_pct = 52;
   int quiet_cycles   = 0;
   bit hold_trigger   = 1'b0;
   bit hold_taken     = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   preemptive_priority_scheduler #(
      .MAX_TASKS(TABLE_SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   schedule_checker #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .loads_taken  (loads_taken),
      .loads_refused(loads_refused),
      .busy_ticks   (busy_ticks),
      .idle_ticks   (idle_ticks),
      .switches     (switches),
      .completions  (completions)
   );

   // watchdog: ends the run after too many cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
               $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
               $display("FAIL");
               $finish;
            end
         end
      end
   end

   // response side: random stalls, plus one long hold-off when asked for
   initial begin
      forever begin
         @(negedge clock);
         if (hold_trigger && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            // block takes one more request, then stalls further requests behind the held response
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // offer one request; called and returning at a falling edge
   task automatic send_request(input req_type r);
      // random idle cycles before the request goes out
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      // hold the request until the block takes it
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic issue_load(input logic [15:0] arr, input logic [15:0] bur,
                             input logic [7:0] pr);
      req_type r;
      r.command = CMD_LOAD;
      r.arrival = arr;
      r.burst   = bur;
      r.prio    = pr;
      if (bur != 16'd0 && slots_used < TABLE_SLOTS)
         slots_used++;
      send_request(r);
   endtask

   task automatic issue_tick();
      req_type r;
      // arrival, burst and prio are don't-care on a tick, so scramble them
      r.command = CMD_TICK;
      r.arrival = 16'($urandom);
      r.burst   = 16'($urandom);
      r.prio    = 8'($urandom);
      ticks_sent++;
      send_request(r);
   endtask

   // a well-formed load, with an arrival mostly near the current time
   task automatic issue_random_load();
      logic [15:0] arr;
      logic [15:0] bur;
      logic [7:0]  pr;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         arr = 16'(ticks_sent + $urandom_range(0, 25));
      else if (pick < 95)
         arr = 16'($urandom_range(0, ticks_sent));
      else
         arr = 16'($urandom);
      pr = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         bur = 16'($urandom_range(1, 10));
      end else if (pick < 95) begin
         bur = 16'($urandom_range(11, 60));
      end else begin
         // long tasks get low priority so they do not starve the rest
         bur = 16'($urandom_range(1, 65535));
         pr  = 8'($urandom_range(200, 255));
      end
      issue_load(arr, bur, pr);
   endtask

   initial begin
      int roll;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      issue_tick();                       // empty table: idle, all done
      issue_load(16'd5, 16'd0, 8'd3);     // zero burst refused
      issue_load(16'd0, 16'd1, 8'd5);
      issue_tick();                       // first run switches and finishes at once
      issue_load(16'd0, 16'd3, 8'd0);     // load after all done clears all_done
      issue_load(16'd0, 16'd2, 8'd0);     // same priority and arrival: lower slot wins
      issue_load(16'd1, 16'd2, 8'd0);     // same priority, later arrival
      issue_load(16'd6, 16'd2, 8'd255);   // lowest priority, arrives later
      repeat (3) issue_tick();
      repeat (2) issue_tick();
      issue_load(16'd9, 16'd1, 8'd0);     // arrives later and runs ahead of the waiting lowest-priority task
      repeat (4) issue_tick();

      // random part: three idling phases, one long hold-off in the last
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct  = 52;
            recv_stall_pct = 25;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            hold_trigger   = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 3 && slots_used < TABLE_SLOTS - 1)
            issue_random_load();
         else if (roll < 5)
            issue_load(16'($urandom), 16'd0, 8'($urandom));
         else
            issue_tick();
      end

      // fill the table, then the widest load and a refusal on a full table
      while (slots_used < TABLE_SLOTS - 1)
         issue_random_load();
      issue_load(16'hFFFF, 16'hFFFF, 8'hFF);
      repeat (2) issue_tick();
      issue_load(16'd0, 16'd1, 8'd0);
      issue_tick();
      req_valid <= 1'b0;

      // drain
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d loads taken, %0d refused, %0d busy and %0d idle ticks",
               loads_taken, loads_refused, busy_ticks, idle_ticks);
      $display("saw %0d task switches and %0d completions, %0d mismatches",
               switches, completions, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### files.f
design/pps_pkg.sv
design/pps_task_mem.sv
design/pps_select.sv
design/preemptive_priority_scheduler.sv
tb/schedule_checker.sv
tb/tb.sv
